FILE: src/sfs_pkg.sv
package sfs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DATA_W      = 31;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_HIGH,
        S_PROBE,
        S_FIN,
        S_DONE
    } sfs_state_t;

endpackage

FILE: src/sorted_table_floor_search_top.sv
// channel  | valid     | ready     | payload
// input    | in_valid  | in_ready  | cmd, entry_size, entry_benefit, search_key
// output   | out_valid | out_ready | found_benefit, status
//
// clear, append and unused commands: result valid in the cycle after accept.
// query: one probe per cycle on the single table read port
// and the one size comparator, at most log2(depth) probes plus the final read.
// in_ready is high only while idle; a result holds until out_ready takes it.
// rst_n clears the entry count and control state; table contents stay undefined.
module sorted_table_floor_search_top
    import sfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [DATA_W-1:0] entry_size,
    input  logic [DATA_W-1:0] entry_benefit,
    input  logic [DATA_W-1:0] search_key,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] found_benefit,
    output logic [1:0]        status
);

    sfs_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] low_reg, low_next;
    logic [ADDR_W-1:0] high_reg, high_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] benefit_reg, benefit_next;
    logic [1:0]        status_reg, status_next;

    logic [DATA_W-1:0] size_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] ben_mem  [TABLE_DEPTH];
    logic [DATA_W-1:0] size_q;
    logic [DATA_W-1:0] ben_q;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    logic              accept;
    logic              cmp_lt;
    logic              cmp_eq;
    logic [ADDR_W-1:0] bound_lo;
    logic [ADDR_W-1:0] bound_hi;
    logic              more;
    logic [CNT_W-1:0]  mid_sum;
    logic [ADDR_W-1:0] mid_calc;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign found_benefit = benefit_reg;
    assign status        = status_reg;

    // shared size comparator
    assign cmp_lt = (size_q < key_reg);
    assign cmp_eq = (size_q == key_reg);

    assign bound_lo = (state_reg == S_PROBE && cmp_lt) ? mid_reg : low_reg;
    assign bound_hi = (state_reg == S_PROBE && !cmp_lt && !cmp_eq) ? mid_reg : high_reg;
    assign more     = ({1'b0, bound_lo} + CNT_W'(1)) < {1'b0, bound_hi};
    assign mid_sum  = {1'b0, bound_lo} + {1'b0, bound_hi};
    assign mid_calc = mid_sum[CNT_W-1:1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_mem[count_reg[ADDR_W-1:0]] <= entry_size;
            ben_mem[count_reg[ADDR_W-1:0]]  <= entry_benefit;
        end
        if (rd_en)
        begin
            size_q <= size_mem[rd_addr];
            ben_q  <= ben_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_QUERY && count_reg != '0)
                        state_next = S_CHK_HIGH;
                    else
                        state_next = S_DONE;
                end
            end
            S_CHK_HIGH:
            begin
                if (cmp_lt || cmp_eq)
                    state_next = S_DONE;
                else if (more)
                    state_next = S_PROBE;
                else
                    state_next = S_FIN;
            end
            S_PROBE:
            begin
                if (cmp_eq)
                    state_next = S_DONE;
                else if (!more)
                    state_next = S_FIN;
            end
            S_FIN:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        mid_next     = mid_reg;
        key_next     = key_reg;
        benefit_next = benefit_reg;
        status_next  = status_reg;
        rd_en        = 1'b0;
        rd_addr      = mid_calc;
        wr_en        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    benefit_next = '0;
                    status_next  = ST_OK;
                    case (cmd)
                        CMD_CLEAR:
                            count_next = '0;
                        CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                                status_next = ST_FULL;
                        end
                        CMD_QUERY:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                key_next  = search_key;
                                low_next  = '0;
                                high_next = ADDR_W'(count_reg - CNT_W'(1));
                                rd_en     = 1'b1;
                                rd_addr   = ADDR_W'(count_reg - CNT_W'(1));
                            end
                        end
                        default:
                            status_next = ST_OK;
                    endcase
                end
            end
            S_CHK_HIGH, S_PROBE:
            begin
                if (cmp_eq || (state_reg == S_CHK_HIGH && cmp_lt))
                    benefit_next = ben_q;
                else
                begin
                    low_next  = bound_lo;
                    high_next = bound_hi;
                    rd_en     = 1'b1;
                    if (more)
                    begin
                        rd_addr  = mid_calc;
                        mid_next = mid_calc;
                    end
                    else
                        rd_addr = bound_lo;
                end
            end
            S_FIN:
                benefit_next = ben_q;
            S_DONE:
                rd_en = 1'b0;
            default:
                rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg     <= low_next;
        high_reg    <= high_next;
        mid_reg     <= mid_next;
        key_reg     <= key_next;
        benefit_reg <= benefit_next;
        status_reg  <= status_next;
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result is pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_QUERY && count_reg == '0)
        |=> (out_valid && status == ST_EMPTY && found_benefit == '0))
        else $error("empty-table query not flagged");

    a_probe_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (low_reg < mid_reg && mid_reg < high_reg))
        else $error("probe index outside search bounds");

    a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_APPEND && count_reg == CNT_W'(TABLE_DEPTH))
        |=> (status == ST_FULL && $stable(count_reg)))
        else $error("append to full table not refused");

endmodule
